[sv/sndu_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the som node distance and update block
package sndu_pkg;

    localparam int MAX_DIMENSION = 256;
    localparam int WEIGHT_BITS   = 16;
    localparam int IDX_W         = $clog2(MAX_DIMENSION);
    localparam int DIM_W         = 9;
    localparam int RATE_W        = 16;
    localparam int SUM_W         = 42;

    typedef enum logic [1:0] {
        F_LOAD   = 2'd0,
        F_DIST   = 2'd1,
        F_ADJUST = 2'd2,
        F_READ   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WB
    } t_state;

    localparam logic RK_DIST = 1'b0;
    localparam logic RK_READ = 1'b1;

endpackage

[sv/som_node_distance_update_top.sv]
`timescale 1ns / 1ps
// top level of one self-organising-map neuron: weight memory, distance and adjust
//
// usage
//  - input channel: an item is taken at a rising edge with start high and busy
//    low; func picks load, distance accumulate, adjust or read for one element
//  - each item runs three steps: accept (weight memory read issued), execute
//    (difference and the one shared multiplier), write-back (memory write,
//    distance sum update, result formed)
//  - busy is high only in the execute cycle, so a new request is taken in the
//    write-back cycle of the previous one, while that one is still written back
//  - a request that reads the entry being written back gets the new weight
//    through a forwarding register
//  - results (distance at a last element, or a weight read) show on the
//    result ports for one cycle with o_result_valid, registered at the end of
//    the write-back step; the receiver cannot stall, so nothing is ever held back
//  - configuration: one register, dimension, written through i_cfg_valid and
//    o_cfg_ready; it is meant to change only while no request is in flight
//  - reset clears the control state, the distance sum and sets dimension to
//    256; weights stay undefined until loaded
module som_node_distance_update_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_func,
    input  logic [sndu_pkg::IDX_W-1:0]         i_element_index,
    input  logic signed [sndu_pkg::WEIGHT_BITS-1:0] i_element_value,
    input  logic [sndu_pkg::RATE_W-1:0]        i_learning_rate,
    input  logic [sndu_pkg::RATE_W-1:0]        i_influence,
    input  logic                               i_last_element,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sndu_pkg::DIM_W-1:0]         i_cfg_data,
    output logic                               o_result_valid,
    output logic                               o_result_kind,
    output logic [sndu_pkg::SUM_W-1:0]         o_distance_squared,
    output logic signed [sndu_pkg::WEIGHT_BITS-1:0] o_weight_value
);
    import sndu_pkg::*;

    localparam int DIFF_W = WEIGHT_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam logic [DIM_W-1:0] MAX_DIM_L = DIM_W'(MAX_DIMENSION);

    // weight memory, single write port, registered read
    logic signed [WEIGHT_BITS-1:0] mem [MAX_DIMENSION];

    t_state r_state, n_state;

    // captured request
    t_func                   r_func;
    logic [IDX_W-1:0]        r_idx;
    logic signed [WEIGHT_BITS-1:0] r_x;
    logic                    r_last;
    logic                    r_ok;
    logic [RATE_W-1:0]       r_rate;

    // memory read data and forwarding
    logic signed [WEIGHT_BITS-1:0] r_rd_data;
    logic                    r_fwd;
    logic signed [WEIGHT_BITS-1:0] r_fwd_data;

    // execute stage results
    logic signed [PROD_W-1:0] r_prod;
    logic signed [WEIGHT_BITS-1:0] r_w;

    logic [DIM_W-1:0]        r_dimension;
    logic [SUM_W-1:0]        r_sum, n_sum;

    logic                    accept;
    logic                    ok_in;
    logic [DIM_W-1:0]        dim_eff;
    logic [2*RATE_W-1:0]     rate_full;
    logic signed [WEIGHT_BITS-1:0] w_cur;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] mul_b;
    logic                    wr_en;
    logic signed [WEIGHT_BITS-1:0] wr_data;
    logic [SUM_W:0]          sum_add;
    logic signed [PROD_W:0]  rnd;
    logic signed [PROD_W:0]  q_full;
    logic                    n_res_valid;
    logic                    n_res_kind;
    logic [SUM_W-1:0]        n_res_dist;
    logic signed [WEIGHT_BITS-1:0] n_res_weight;

    // ---- request side
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign dim_eff     = (r_dimension > MAX_DIM_L) ? MAX_DIM_L : r_dimension;
    assign ok_in       = DIM_W'(i_element_index) < dim_eff;
    // rounded product of learning rate and influence, q0.16
    assign rate_full   = (i_learning_rate * i_influence) + (2*RATE_W)'(32768);

    // ---- execute: weight with forwarding, difference, shared multiplier operand
    assign w_cur = r_fwd ? r_fwd_data : r_rd_data;
    assign diff  = DIFF_W'(r_x) - DIFF_W'(w_cur);
    assign mul_b = (r_func == F_DIST) ? diff : $signed({1'b0, r_rate});

    // ---- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_WB;
            end
            S_WB: begin
                n_state = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---- outputs and write-back datapath
    always_comb begin
        busy         = (r_state == S_EXEC);
        wr_en        = 1'b0;
        wr_data      = r_x;
        n_sum        = r_sum;
        n_res_valid  = 1'b0;
        n_res_kind   = RK_DIST;
        n_res_dist   = '0;
        n_res_weight = '0;
        // saturating accumulate of the square, always non-negative
        sum_add      = {1'b0, r_sum} + (SUM_W+1)'(r_prod[PROD_W-3:0]);
        // round half up from q8.24 to q8.8
        rnd          = (PROD_W+1)'(r_prod) + (PROD_W+1)'(32768);
        q_full       = rnd >>> 16;
        if (r_state == S_WB) begin
            case (r_func)
                F_LOAD: begin
                    wr_en   = r_ok;
                    wr_data = r_x;
                end
                F_DIST: begin
                    if (r_ok) begin
                        n_sum = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
                    end
                    if (r_last) begin
                        n_res_valid = 1'b1;
                        n_res_kind  = RK_DIST;
                        n_res_dist  = n_sum;
                        n_sum       = '0;
                    end
                end
                F_ADJUST: begin
                    wr_en   = r_ok;
                    wr_data = r_w + q_full[WEIGHT_BITS-1:0];
                end
                F_READ: begin
                    n_res_valid  = 1'b1;
                    n_res_kind   = RK_READ;
                    n_res_weight = r_ok ? r_w : '0;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // ---- memory access
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_idx] <= wr_data;
        end
        if (accept) begin
            r_rd_data <= mem[i_element_index];
        end
    end

    // ---- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sum          <= '0;
            r_dimension    <= DIM_W'(256);
            r_fwd          <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_sum          <= n_sum;
            o_result_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dimension <= i_cfg_data;
            end
            // new request reads the entry written back in this very cycle
            if (accept) begin
                r_fwd <= wr_en && (i_element_index == r_idx);
            end
        end
    end

    // ---- payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func     <= t_func'(i_func);
            r_idx      <= i_element_index;
            r_x        <= i_element_value;
            r_last     <= i_last_element;
            r_ok       <= ok_in;
            r_rate     <= rate_full[2*RATE_W-1:RATE_W];
            r_fwd_data <= wr_data;
        end
        if (r_state == S_EXEC) begin
            r_w    <= w_cur;
            r_prod <= diff * mul_b;
        end
        o_result_kind      <= n_res_kind;
        o_distance_squared <= n_res_dist;
        o_weight_value     <= n_res_weight;
    end

endmodule

[sv/sndu_checker.sv]
`timescale 1ns / 1ps
// port-level checker for the som node block and its bind
module sndu_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_result_valid,
    input logic                               o_result_kind,
    input logic [sndu_pkg::SUM_W-1:0]         o_distance_squared,
    input logic [sndu_pkg::WEIGHT_BITS-1:0]   o_weight_value
);
    import sndu_pkg::*;

    // busy lasts a single cycle per request
    a_busy_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // an accepted request raises busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken without busy");

    // a result only follows a request, after its execute and write-back steps
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy, 2))
        else $error("result without a matching request");

    // unused result field is zero
    a_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ((o_result_kind == RK_DIST) ? (o_weight_value == '0)
                                                       : (o_distance_squared == '0)))
        else $error("unused result field not zero");

endmodule

bind som_node_distance_update_top sndu_checker u_sndu_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_result_valid     (o_result_valid),
    .o_result_kind      (o_result_kind),
    .o_distance_squared (o_distance_squared),
    .o_weight_value     (o_weight_value)
);
